// File: sv/split_info_adjustment_parser_assert.svh
// Assertion macros for the split-info adjustment parser.
`ifndef SPLIT_INFO_ADJUSTMENT_PARSER_ASSERT_SVH
`define SPLIT_INFO_ADJUSTMENT_PARSER_ASSERT_SVH

// checked out of reset only
`define SIPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset as well
`define SIPA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/sipa_pkg.sv
// Types and constants shared by the split-info adjustment parser.
package sipa_pkg;

  localparam logic [7:0] VERSION_RST    = 8'd127;
  localparam logic [7:0] KIND_LIMIT_RST = 8'd16;
  localparam int unsigned QDEPTH        = 2;

  typedef enum logic [0:0] {
    REG_EXPECTED_VERSION = 1'b0,
    REG_KIND_LIMIT       = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    TK_NUM  = 2'd0,
    TK_LONG = 2'd1,
    TK_VOK  = 2'd2,
    TK_VBAD = 2'd3
  } tok_e;

  typedef struct packed {
    tok_e        code;
    logic [63:0] value;
  } tok_t;

  typedef enum logic [2:0] {
    ST_ENTRY       = 3'd0,
    ST_DONE        = 3'd1,
    ST_BAD_VERSION = 3'd2,
    ST_BAD_KIND    = 3'd3,
    ST_TOO_LONG    = 3'd4,
    ST_BAD_INDEX   = 3'd5
  } status_e;

  typedef enum logic [9:0] {
    PH_IDLE        = 10'b0000000001,
    PH_SEC_COUNT   = 10'b0000000010,
    PH_SRC_IDX     = 10'b0000000100,
    PH_TGT_IDX     = 10'b0000001000,
    PH_TGT_COUNT   = 10'b0000010000,
    PH_TGT_DELTA   = 10'b0000100000,
    PH_GRP_COUNT   = 10'b0001000000,
    PH_KIND        = 10'b0010000000,
    PH_DELTA_COUNT = 10'b0100000000,
    PH_SRC_DELTA   = 10'b1000000000
  } phase_e;

endpackage

// File: sv/sipa_front.sv
// Front end: byte intake, version check and ULEB128 number assembly.
module sipa_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       data_byte_i,
  input  logic             start_req_i,
  input  logic [7:0]       expected_version_i,
  output logic             tok_valid_o,
  output sipa_pkg::tok_t   tok_o,
  input  logic             tok_ready_i
);
  import sipa_pkg::*;

  logic [63:0] accum_q, accum_d;
  logic [6:0]  shift_q, shift_d;
  logic [6:0]  payload;
  logic [63:0] merged;
  logic        too_long;
  logic        accept;

  assign payload    = data_byte_i[6:0];
  assign too_long   = (shift_q >= 7'd64) || (shift_q == 7'd63 && payload > 7'd1);
  assign merged     = accum_q | ({57'd0, payload} << shift_q);
  assign in_ready_o = tok_ready_i;
  assign accept     = in_valid_i && tok_ready_i;

  always_comb begin
    accum_d     = accum_q;
    shift_d     = shift_q;
    tok_valid_o = 1'b0;
    tok_o.code  = TK_NUM;
    tok_o.value = merged;
    if (accept) begin
      if (start_req_i) begin
        accum_d     = '0;
        shift_d     = '0;
        tok_valid_o = 1'b1;
        tok_o.value = '0;
        tok_o.code  = (data_byte_i == expected_version_i) ? TK_VOK : TK_VBAD;
      end else if (too_long) begin
        accum_d     = '0;
        shift_d     = '0;
        tok_valid_o = 1'b1;
        tok_o.code  = TK_LONG;
        tok_o.value = '0;
      end else if (data_byte_i[7]) begin
        accum_d = merged;
        shift_d = shift_q + 7'd7;
      end else begin
        accum_d     = '0;
        shift_d     = '0;
        tok_valid_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= '0;
      shift_q <= '0;
    end else begin
      accum_q <= accum_d;
      shift_q <= shift_d;
    end
  end

endmodule

// File: sv/sipa_queue.sv
// Two-entry item queue between front end and back end.
module sipa_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sipa_pkg::tok_t push_tok_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output sipa_pkg::tok_t pop_tok_o,
  input  logic           pop_i
);
  import sipa_pkg::*;

  tok_t       mem_q [QDEPTH];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign push_ready_o = (count_q != 2'(QDEPTH));
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_tok_o    = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// File: sv/sipa_back.sv
// Back end: nested group walk, offset accumulation and result register.
module sipa_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     kind_limit_i,
  input  logic           tok_valid_i,
  input  sipa_pkg::tok_t tok_i,
  output logic           tok_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [2:0]     status_o,
  output logic [7:0]     source_section_o,
  output logic [7:0]     target_section_o,
  output logic [63:0]    source_offset_o,
  output logic [63:0]    target_offset_o,
  output logic [7:0]     adjust_kind_o,
  output logic           last_o
);
  import sipa_pkg::*;

  phase_e      phase_q, phase_d;
  logic [63:0] sections_q, sections_d;
  logic [63:0] targets_q, targets_d;
  logic [63:0] groups_q, groups_d;
  logic [63:0] deltas_q, deltas_d;
  logic [63:0] tgt_off_q, tgt_off_d;
  logic [63:0] src_off_q, src_off_d;
  logic [7:0]  src_sec_q, src_sec_d;
  logic [7:0]  tgt_sec_q, tgt_sec_d;
  logic [7:0]  kind_q, kind_d;

  logic        out_valid_q;
  status_e     out_status_q;
  logic [7:0]  out_src_sec_q, out_tgt_sec_q, out_kind_q;
  logic [63:0] out_src_off_q, out_tgt_off_q;
  logic        out_last_q;

  logic        pop;
  logic [63:0] v;
  logic        sec_end, tgt_end, grp_end;
  phase_e      tgt_phase, grp_phase;
  logic        tgt_done, grp_done;
  logic        clear, go;
  logic        res_valid, res_entry, res_last;
  status_e     res_status;

  assign tok_ready_o = !out_valid_q || out_ready_i;
  assign pop         = tok_valid_i && tok_ready_o;
  assign v           = tok_i.value;

  assign sec_end   = (sections_q == 64'd1);
  assign tgt_end   = (targets_q == 64'd1);
  assign grp_end   = (groups_q == 64'd1);
  assign tgt_phase = tgt_end ? PH_SRC_IDX : PH_TGT_DELTA;
  assign tgt_done  = tgt_end && sec_end;
  assign grp_phase = grp_end ? tgt_phase : PH_KIND;
  assign grp_done  = grp_end && tgt_done;

  always_comb begin
    phase_d    = phase_q;
    sections_d = sections_q;
    targets_d  = targets_q;
    groups_d   = groups_q;
    deltas_d   = deltas_q;
    tgt_off_d  = tgt_off_q;
    src_off_d  = src_off_q;
    src_sec_d  = src_sec_q;
    tgt_sec_d  = tgt_sec_q;
    kind_d     = kind_q;
    clear      = 1'b0;
    go         = 1'b0;
    res_valid  = 1'b0;
    res_entry  = 1'b0;
    res_last   = 1'b1;
    res_status = ST_DONE;
    case (tok_i.code)
      TK_VBAD: begin
        clear      = 1'b1;
        res_valid  = 1'b1;
        res_status = ST_BAD_VERSION;
      end
      TK_VOK: begin
        clear = 1'b1;
        go    = 1'b1;
      end
      TK_LONG: begin
        if (phase_q != PH_IDLE) begin
          clear      = 1'b1;
          res_valid  = 1'b1;
          res_status = ST_TOO_LONG;
        end
      end
      TK_NUM: begin
        case (phase_q)
          PH_SEC_COUNT: begin
            sections_d = v;
            if (v == 64'd0) begin
              clear     = 1'b1;
              res_valid = 1'b1;
            end else begin
              phase_d = PH_SRC_IDX;
            end
          end
          PH_SRC_IDX: begin
            if (v > 64'd255) begin
              clear      = 1'b1;
              res_valid  = 1'b1;
              res_status = ST_BAD_INDEX;
            end else begin
              src_sec_d = v[7:0];
              phase_d   = PH_TGT_IDX;
            end
          end
          PH_TGT_IDX: begin
            if (v > 64'd255) begin
              clear      = 1'b1;
              res_valid  = 1'b1;
              res_status = ST_BAD_INDEX;
            end else begin
              tgt_sec_d = v[7:0];
              phase_d   = PH_TGT_COUNT;
            end
          end
          PH_TGT_COUNT: begin
            targets_d = v;
            tgt_off_d = '0;
            if (v == 64'd0) begin
              sections_d = sections_q - 64'd1;
              if (sec_end) begin
                clear     = 1'b1;
                res_valid = 1'b1;
              end else begin
                phase_d = PH_SRC_IDX;
              end
            end else begin
              phase_d = PH_TGT_DELTA;
            end
          end
          PH_TGT_DELTA: begin
            tgt_off_d = tgt_off_q + v;
            phase_d   = PH_GRP_COUNT;
          end
          PH_GRP_COUNT: begin
            groups_d = v;
            if (v == 64'd0) begin
              targets_d = targets_q - 64'd1;
              if (tgt_end) sections_d = sections_q - 64'd1;
              if (tgt_done) begin
                clear     = 1'b1;
                res_valid = 1'b1;
              end else begin
                phase_d = tgt_phase;
              end
            end else begin
              phase_d = PH_KIND;
            end
          end
          PH_KIND: begin
            if (v >= {56'd0, kind_limit_i}) begin
              clear      = 1'b1;
              res_valid  = 1'b1;
              res_status = ST_BAD_KIND;
            end else begin
              kind_d  = v[7:0];
              phase_d = PH_DELTA_COUNT;
            end
          end
          PH_DELTA_COUNT: begin
            deltas_d  = v;
            src_off_d = '0;
            if (v == 64'd0) begin
              groups_d = groups_q - 64'd1;
              if (grp_end) targets_d = targets_q - 64'd1;
              if (grp_end && tgt_end) sections_d = sections_q - 64'd1;
              if (grp_done) begin
                clear     = 1'b1;
                res_valid = 1'b1;
              end else begin
                phase_d = grp_phase;
              end
            end else begin
              phase_d = PH_SRC_DELTA;
            end
          end
          PH_SRC_DELTA: begin
            src_off_d  = src_off_q + v;
            deltas_d   = deltas_q - 64'd1;
            res_valid  = 1'b1;
            res_entry  = 1'b1;
            res_status = ST_ENTRY;
            res_last   = 1'b0;
            if (deltas_q == 64'd1) begin
              groups_d = groups_q - 64'd1;
              if (grp_end) targets_d = targets_q - 64'd1;
              if (grp_end && tgt_end) sections_d = sections_q - 64'd1;
              if (grp_done) begin
                clear    = 1'b1;
                res_last = 1'b1;
              end else begin
                phase_d = grp_phase;
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (clear) begin
      phase_d    = go ? PH_SEC_COUNT : PH_IDLE;
      sections_d = '0;
      targets_d  = '0;
      groups_d   = '0;
      deltas_d   = '0;
      tgt_off_d  = '0;
      src_off_d  = '0;
      src_sec_d  = '0;
      tgt_sec_d  = '0;
      kind_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      sections_q <= '0;
      targets_q  <= '0;
      groups_q   <= '0;
      deltas_q   <= '0;
      tgt_off_q  <= '0;
      src_off_q  <= '0;
      src_sec_q  <= '0;
      tgt_sec_q  <= '0;
      kind_q     <= '0;
    end else if (pop) begin
      phase_q    <= phase_d;
      sections_q <= sections_d;
      targets_q  <= targets_d;
      groups_q   <= groups_d;
      deltas_q   <= deltas_d;
      tgt_off_q  <= tgt_off_d;
      src_off_q  <= src_off_d;
      src_sec_q  <= src_sec_d;
      tgt_sec_q  <= tgt_sec_d;
      kind_q     <= kind_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && res_valid) begin
      out_status_q  <= res_status;
      out_last_q    <= res_last;
      out_src_sec_q <= res_entry ? src_sec_q : 8'd0;
      out_tgt_sec_q <= res_entry ? tgt_sec_q : 8'd0;
      out_kind_q    <= res_entry ? kind_q : 8'd0;
      out_src_off_q <= res_entry ? (src_off_q + v) : 64'd0;
      out_tgt_off_q <= res_entry ? tgt_off_q : 64'd0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign source_section_o = out_src_sec_q;
  assign target_section_o = out_tgt_sec_q;
  assign source_offset_o  = out_src_off_q;
  assign target_offset_o  = out_tgt_off_q;
  assign adjust_kind_o    = out_kind_q;
  assign last_o           = out_last_q;

`include "split_info_adjustment_parser_assert.svh"

  `SIPA_ASSERT(a_bad_version_out,
    (pop && tok_i.code == TK_VBAD) |=>
      (out_valid_q && out_status_q == ST_BAD_VERSION && out_last_q),
    "bad version item not reported")
  `SIPA_ASSERT(a_sections_live,
    (phase_q != PH_IDLE && phase_q != PH_SEC_COUNT) |-> (sections_q != 64'd0),
    "section count ran out inside a parse")
  `SIPA_ASSERT(a_counts_live,
    (phase_q == PH_SRC_DELTA) |->
      (deltas_q != 64'd0 && groups_q != 64'd0 && targets_q != 64'd0),
    "inner count ran out inside a group")
  `SIPA_ASSERT_RST(a_reset_quiet,
    !rst_ni |=> (!out_valid_q && phase_q == PH_IDLE),
    "result or parse live during reset")

endmodule

// File: sv/split_info_adjustment_parser.sv
// Top level of the split-info adjustment parser: config registers and front/queue/back.
// A byte that completes a number is queued; its item is then registered onto out_valid_o.
// One byte per cycle is taken; the back end retires one queued number or marker per cycle.
// A full two-entry queue stalls in_ready_o; a held result register stalls the back end.
// Reset (rst_ni low, async) idles the parse, empties queue and result, loads register defaults.
module split_info_adjustment_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [7:0]  source_section_o,
  output logic [7:0]  target_section_o,
  output logic [63:0] source_offset_o,
  output logic [63:0] target_offset_o,
  output logic [7:0]  adjust_kind_o,
  output logic        last_o
);
  import sipa_pkg::*;

  logic [7:0] version_q;
  logic [7:0] kind_limit_q;
  reg_idx_e   reg_idx;
  logic       wr_en;

  logic       f_valid, f_ready;
  tok_t       f_tok;
  logic       b_valid, b_ready;
  tok_t       b_tok;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_EXPECTED_VERSION: prdata = {24'd0, version_q};
      REG_KIND_LIMIT:       prdata = {24'd0, kind_limit_q};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q    <= VERSION_RST;
      kind_limit_q <= KIND_LIMIT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_EXPECTED_VERSION: version_q <= pwdata[7:0];
        REG_KIND_LIMIT:       kind_limit_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  sipa_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .data_byte_i        (data_byte_i),
    .start_req_i        (start_req_i),
    .expected_version_i (version_q),
    .tok_valid_o        (f_valid),
    .tok_o              (f_tok),
    .tok_ready_i        (f_ready)
  );

  sipa_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (f_valid),
    .push_tok_i   (f_tok),
    .push_ready_o (f_ready),
    .pop_valid_o  (b_valid),
    .pop_tok_o    (b_tok),
    .pop_i        (b_ready)
  );

  sipa_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .kind_limit_i     (kind_limit_q),
    .tok_valid_i      (b_valid),
    .tok_i            (b_tok),
    .tok_ready_o      (b_ready),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .source_section_o (source_section_o),
    .target_section_o (target_section_o),
    .source_offset_o  (source_offset_o),
    .target_offset_o  (target_offset_o),
    .adjust_kind_o    (adjust_kind_o),
    .last_o           (last_o)
  );

endmodule
